>>> sv/sctf_pkg.sv
package sctf_pkg;

  // Framing characters
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  // Bytes of a data frame around the payload: A T, 4-byte word, length, 2 trailer
  localparam int unsigned FRAME_OVERHEAD = 9;
  // Bytes ahead of the first data byte; also the bytes needed before parsing
  localparam int unsigned HEADER_BYTES   = 7;
  localparam int unsigned DATA_SLOTS     = 8;

  // Result kinds
  localparam logic KIND_CAN = 1'b0;
  localparam logic KIND_OK  = 1'b1;

  typedef struct packed {
    logic                        kind;
    logic [28:0]                 ext_id;
    logic [3:0]                  length;
    logic [DATA_SLOTS-1:0][7:0]  data;
  } result_t;

endpackage

>>> sv/sctf_rx_if.sv
interface sctf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

>>> sv/sctf_frame_if.sv
interface sctf_frame_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [28:0] ext_id;
  logic [3:0]  length;
  logic [7:0]  data0;
  logic [7:0]  data1;
  logic [7:0]  data2;
  logic [7:0]  data3;
  logic [7:0]  data4;
  logic [7:0]  data5;
  logic [7:0]  data6;
  logic [7:0]  data7;

  modport source (output valid, output kind, output ext_id, output length,
                  output data0, output data1, output data2, output data3,
                  output data4, output data5, output data6, output data7,
                  input ready);
  modport sink   (input valid, input kind, input ext_id, input length,
                  input data0, input data1, input data2, input data3,
                  input data4, input data5, input data6, input data7,
                  output ready);
endinterface

>>> sv/serial_to_can_frame_deframer.sv
// Serial-to-CAN deframer: takes one received byte per beat and returns a CAN
// data frame (29-bit identifier, length, eight zero-padded data bytes) or an
// OK reply for the AT+AT CR LF command. A byte is taken every cycle while the
// output does not stall; the byte that completes a frame is parsed in the input
// register against the window register of FRAME_OVERHEAD + MAX_LENGTH bytes,
// and its result is then held in the result register. Bytes that do not start
// a valid frame are discarded one or two at a time as the framing demands; the
// window needs no clearing after reset.
module serial_to_can_frame_deframer import sctf_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  sctf_rx_if.sink      rx_i,
  sctf_frame_if.source frame_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       free, step, res_valid;
  result_t    res;

  // Advance the input register whenever the result register can take a beat
  assign step       = s1_valid_q && free;
  assign rx_i.ready = !s1_valid_q || free;
  assign s1_valid_d = (rx_i.valid && rx_i.ready) ? 1'b1 : (step ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_data;
    end
  end

  sctf_parser #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sctf_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .free_o  (free),
    .frame_o (frame_o)
  );

endmodule

>>> sv/sctf_parser.sv
module sctf_parser import sctf_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned DEPTH = FRAME_OVERHEAD + MAX_LENGTH;
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  logic [7:0]       win_q [DEPTH];
  logic [7:0]       win_d [DEPTH];
  logic [7:0]       v     [DEPTH];
  logic [FillW-1:0] fill_q, fill_d, fill_nx;

  logic       append_ok, eval, start_ok, is_cmd, cmd_ok, len_big, complete;
  logic [7:0] flen;
  logic       res_kind;
  logic [7:0] slot [DATA_SLOTS];

  // Window as it stands with the new byte appended
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      v[k] = (fill_q == FillW'(k)) ? byte_i : win_q[k];
    end
  end

  assign append_ok = (fill_q < FillW'(DEPTH));
  assign fill_nx   = fill_q + FillW'(1);
  assign eval      = (fill_nx >= FillW'(HEADER_BYTES));

  // Header checks on the first seven bytes
  assign start_ok = (v[0] == CHAR_A) && (v[1] == CHAR_T);
  assign is_cmd   = (v[2] == CHAR_PLUS);
  assign cmd_ok   = (v[3] == CHAR_A) && (v[4] == CHAR_T) &&
                    (v[5] == CHAR_CR) && (v[6] == CHAR_LF);
  assign len_big  = (v[6] > 8'(MAX_LENGTH));
  assign flen     = 8'(FRAME_OVERHEAD) + v[6];
  assign complete = (8'(fill_nx) == flen);

  // Decide what the byte does to the window
  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    res_valid_o = 1'b0;
    res_kind    = KIND_CAN;
    if (step_i && append_ok) begin
      priority if (!eval) begin
        win_d  = v;
        fill_d = fill_nx;
      end else if (!start_ok || (is_cmd && !cmd_ok)) begin
        for (int k = 0; k < DEPTH - 1; k++) win_d[k] = v[k+1];
        fill_d = fill_nx - FillW'(1);
      end else if (is_cmd) begin
        fill_d      = '0;
        res_valid_o = 1'b1;
        res_kind    = KIND_OK;
      end else if (len_big) begin
        for (int k = 0; k < DEPTH - 2; k++) win_d[k] = v[k+2];
        fill_d = fill_nx - FillW'(2);
      end else if (complete) begin
        fill_d      = '0;
        res_valid_o = 1'b1;
      end else begin
        win_d  = v;
        fill_d = fill_nx;
      end
    end
  end

  // Result fields; an OK reply carries all zero
  logic [31:0] word;
  assign word = {v[2], v[3], v[4], v[5]};

  for (genvar i = 0; i < DATA_SLOTS; i++) begin : g_data
    if (i < MAX_LENGTH) begin : g_used
      assign slot[i] = ((res_kind == KIND_CAN) && (v[6] > 8'(i)))
                       ? win_q[HEADER_BYTES + i] : 8'h00;
    end else begin : g_unused
      assign slot[i] = 8'h00;
    end
  end

  always_comb begin
    res_o.kind   = res_kind;
    res_o.ext_id = (res_kind == KIND_OK) ? '0 : word[31:3];
    res_o.length = (res_kind == KIND_OK) ? '0 : v[6][3:0];
    for (int i = 0; i < DATA_SLOTS; i++) res_o.data[i] = slot[i];
  end

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Hold the window bytes
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

>>> sv/sctf_out_stage.sv
module sctf_out_stage import sctf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  result_t  res_i,
  output logic     free_o,
  sctf_frame_if.source frame_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Register is free when empty or its beat leaves this cycle
  assign free_o  = !valid_q || frame_o.ready;
  assign valid_d = load_i ? 1'b1 : (frame_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign frame_o.valid  = valid_q;
  assign frame_o.kind   = res_q.kind;
  assign frame_o.ext_id = res_q.ext_id;
  assign frame_o.length = res_q.length;
  assign frame_o.data0  = res_q.data[0];
  assign frame_o.data1  = res_q.data[1];
  assign frame_o.data2  = res_q.data[2];
  assign frame_o.data3  = res_q.data[3];
  assign frame_o.data4  = res_q.data[4];
  assign frame_o.data5  = res_q.data[5];
  assign frame_o.data6  = res_q.data[6];
  assign frame_o.data7  = res_q.data[7];

endmodule
